/* hdl/ttf_pkg.sv */
// Shared constants, types and state encoding for the triangle tangent frame core.
// Used by the serial arithmetic units and by the top level sequencer.
// No dependencies.
package ttf_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 14;

  localparam int POS_W   = 32;
  localparam int TRI_W   = 20;
  localparam int DELTA_W = POS_W + 1;
  localparam int MAG_W   = 30;
  localparam int ACC_W   = 2 * MAG_W + 3;
  localparam int VMAG_W  = 2 * MAG_W + 1;
  localparam int SUM_W   = 2 * MAG_W + 2;
  localparam int LEN_W   = MAG_W + 1;
  localparam int REM_W   = LEN_W + 2;
  localparam int QUO_W   = OUT_FRAC_BITS + 2;
  localparam int NUM_W   = MAG_W + OUT_FRAC_BITS + 1;
  localparam int DSH_W   = LEN_W + QUO_W - 1;
  localparam int OUT_W   = 16;
  localparam int N_PASS  = 7;

  localparam int IN_FIELDS_W  = 5 * POS_W + TRI_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 6 * OUT_W + TRI_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic signed [DELTA_W-1:0] ONE_IN  = DELTA_W'(1) << IN_FRAC_BITS;
  localparam logic [QUO_W-1:0]          ONE_OUT = QUO_W'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic             neg_ab;
    logic [MAG_W-1:0] c;
    logic [MAG_W-1:0] e;
    logic             neg_ce;
  } mac_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_MAC, S_MACW, S_LOAD, S_NORM, S_SQ, S_SQW,
    S_SQRT, S_SQRTW, S_DIV, S_DIVW, S_OUT
  } state_t;

endpackage

/* hdl/ttf_mac.sv */
// Bit-serial multiply-accumulate unit: result = (+/-)a*b + (+/-)c*e.
// Multiplier bits are shifted out most significant first, one per cycle.
// Depends on ttf_pkg.
module ttf_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  ttf_pkg::mac_op_t                   op,
  output logic                               done,
  output logic signed [ttf_pkg::ACC_W-1:0]   result
);
  import ttf_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic                    run_r, run_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [MAG_W-1:0]        b_r, b_nxt, e_r, e_nxt;
  logic signed [ACC_W-1:0] sa_r, sa_nxt, sc_r, sc_nxt, sac_r, sac_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, sel;
  logic signed [ACC_W-1:0] ea, ec;

  always_comb begin
    ea = $signed(ACC_W'(op.a));
    ec = $signed(ACC_W'(op.c));
    case ({b_r[MAG_W-1], e_r[MAG_W-1]})
      2'b10:   sel = sa_r;
      2'b01:   sel = sc_r;
      2'b11:   sel = sac_r;
      default: sel = '0;
    endcase
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    e_nxt    = e_r;
    sa_nxt   = sa_r;
    sc_nxt   = sc_r;
    sac_nxt  = sac_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(MAG_W - 1);
      b_nxt   = op.b;
      e_nxt   = op.e;
      sa_nxt  = op.neg_ab ? -ea : ea;
      sc_nxt  = op.neg_ce ? -ec : ec;
      sac_nxt = (op.neg_ab ? -ea : ea) + (op.neg_ce ? -ec : ec);
      acc_nxt = '0;
    end else if (run_r) begin
      acc_nxt = (acc_r <<< 1) + sel;
      b_nxt   = b_r << 1;
      e_nxt   = e_r << 1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    b_r   <= b_nxt;
    e_r   <= e_nxt;
    sa_r  <= sa_nxt;
    sc_r  <= sc_nxt;
    sac_r <= sac_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

/* hdl/ttf_sqrt.sv */
// Digit-serial floor square root, two radicand bits per cycle.
// Takes the sum of squares and returns the vector length.
// Depends on ttf_pkg.
module ttf_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ttf_pkg::SUM_W-1:0]     x,
  output logic                          done,
  output logic [ttf_pkg::LEN_W-1:0]     root
);
  import ttf_pkg::*;

  localparam int ITER  = SUM_W / 2;
  localparam int CNT_W = $clog2(ITER);
  localparam int TW    = REM_W + 2;

  logic                run_r, run_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    x_r, x_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]    root_r, root_nxt;
  logic [TW-1:0]       rem_t, trial, diff;
  logic                ge;

  always_comb begin
    rem_t    = {rem_r, x_r[SUM_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = rem_t >= trial;
    diff     = rem_t - trial;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = CNT_W'(ITER - 1);
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      x_nxt    = x_r << 2;
      rem_nxt  = ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
      root_nxt = {root_r[LEN_W-2:0], ge};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* hdl/ttf_div.sv */
// Restoring divider producing one quotient bit per cycle.
// Scales a normalised component by the reciprocal of the vector length.
// Depends on ttf_pkg.
module ttf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ttf_pkg::NUM_W-1:0]     num,
  input  logic [ttf_pkg::LEN_W-1:0]     den,
  output logic                          done,
  output logic [ttf_pkg::QUO_W-1:0]     quo
);
  import ttf_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic              run_r, run_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic              ge;

  always_comb begin
    ge       = DSH_W'(rem_r) >= dsh_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(QUO_W - 1);
      rem_nxt = num;
      dsh_nxt = {den, (QUO_W - 1)'(0)};
      q_nxt   = '0;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[NUM_W-1:0];
      end
      q_nxt   = {q_r[QUO_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* hdl/triangle_tangent_frame_core.sv */
// Triangle tangent frame core: holds two corners and on the third computes the unit
// tangent and bitangent. The first and second corners are stored as they are accepted;
// after the third, input is held off while the bit-serial multiply unit (13 product
// pairs), the normalising shifts and the serial square root and divider run; a zero
// determinant cuts this short and a zero-length vector skips its root and divide. A new corner
// is accepted while a word waits; reset clears the count and output and sets the UV flag.
module triangle_tangent_frame_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, triangle_index, zero padding
  input  logic [ttf_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tangent_x/y/z, bitangent_x/y/z, tri_out, zero padding
  output logic [ttf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // degenerate
  output logic                                out_tuser
);
  import ttf_pkg::*;

  state_t                  state_r, state_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    uv_r;
  logic [POS_W-1:0]        hp_r [6];
  logic [POS_W-1:0]        hp_nxt [6];
  logic [POS_W-1:0]        ht_r [4];
  logic [POS_W-1:0]        ht_nxt [4];
  logic [TRI_W-1:0]        tri_r, tri_nxt;
  logic signed [DELTA_W-1:0] dr_r [6];
  logic signed [DELTA_W-1:0] dr_nxt [6];
  logic signed [DELTA_W-1:0] tr_r [4];
  logic signed [DELTA_W-1:0] tr_nxt [4];
  logic [MAG_W-1:0]        dm_r [6];
  logic [MAG_W-1:0]        dm_nxt [6];
  logic [MAG_W-1:0]        tm_r [4];
  logic [MAG_W-1:0]        tm_nxt [4];
  logic [5:0]              dn_r, dn_nxt;
  logic [3:0]              tn_r, tn_nxt;
  logic [2:0]              pass_r, pass_nxt;
  logic signed [ACC_W-1:0] w_r [N_PASS];
  logic signed [ACC_W-1:0] w_nxt [N_PASS];
  logic                    vec_r, vec_nxt;
  logic [VMAG_W-1:0]       a_r [3];
  logic [VMAG_W-1:0]       a_nxt [3];
  logic [2:0]              an_r, an_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [1:0]              comp_r, comp_nxt;
  logic [OUT_W-1:0]        vo_r [6];
  logic [OUT_W-1:0]        vo_nxt [6];
  logic                    degen_r, degen_nxt;
  logic                    ov_r, ov_nxt;
  logic [OUT_TDATA_W-1:0]  od_r, od_nxt;
  logic                    ou_r, ou_nxt;

  logic                    in_acc;
  logic signed [DELTA_W-1:0] p0 [3];
  logic signed [DELTA_W-1:0] dsub [6];
  logic signed [DELTA_W-1:0] tsub [4];
  logic [DELTA_W-1:0]      dmag [6];
  logic [DELTA_W-1:0]      tmag [4];
  logic [DELTA_W-1:0]      dor, tor;
  logic [1:0]              dsh, tsh;
  logic signed [DELTA_W-1:0] u0, v0;
  logic signed [ACC_W-1:0] wsel, wabs;
  logic [VMAG_W-1:0]       aor, asel;
  mac_op_t                 mac_op;
  logic                    mac_start, mac_done;
  logic signed [ACC_W-1:0] mac_res;
  logic                    sq_done, dv_done;
  logic [LEN_W-1:0]        sq_root;
  logic [QUO_W-1:0]        dv_quo, qs;
  logic [NUM_W-1:0]        dv_num;
  logic [2:0]              vo_idx;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = $signed({in_tdata[i*POS_W+POS_W-1], in_tdata[i*POS_W +: POS_W]});
      dsub[i]   = $signed({hp_r[3+i][POS_W-1], hp_r[3+i]}) - p0[i];
      dsub[3+i] = $signed({hp_r[i][POS_W-1], hp_r[i]}) - p0[i];
    end
    u0 = $signed({in_tdata[4*POS_W-1], in_tdata[3*POS_W +: POS_W]});
    v0 = $signed({in_tdata[5*POS_W-1], in_tdata[4*POS_W +: POS_W]});
    if (uv_r) begin
      tsub[0] = $signed({ht_r[2][POS_W-1], ht_r[2]}) - u0;
      tsub[1] = v0 - $signed({ht_r[3][POS_W-1], ht_r[3]});
      tsub[2] = $signed({ht_r[0][POS_W-1], ht_r[0]}) - u0;
      tsub[3] = v0 - $signed({ht_r[1][POS_W-1], ht_r[1]});
    end else begin
      tsub[0] = ONE_IN;
      tsub[1] = '0;
      tsub[2] = '0;
      tsub[3] = -ONE_IN;
    end
  end

  always_comb begin
    dor = '0;
    tor = '0;
    for (int i = 0; i < 6; i++) begin
      dmag[i] = dr_r[i][DELTA_W-1] ? DELTA_W'(-dr_r[i]) : DELTA_W'(dr_r[i]);
      dor     = dor | dmag[i];
    end
    for (int i = 0; i < 4; i++) begin
      tmag[i] = tr_r[i][DELTA_W-1] ? DELTA_W'(-tr_r[i]) : DELTA_W'(tr_r[i]);
      tor     = tor | tmag[i];
    end
    dsh = dor[MAG_W+2] ? 2'd3 : dor[MAG_W+1] ? 2'd2 : dor[MAG_W] ? 2'd1 : 2'd0;
    tsh = tor[MAG_W+2] ? 2'd3 : tor[MAG_W+1] ? 2'd2 : tor[MAG_W] ? 2'd1 : 2'd0;
  end

  always_comb begin
    case (comp_r)
      2'd1:    asel = a_r[1];
      2'd2:    asel = a_r[2];
      default: asel = a_r[0];
    endcase
    aor = a_r[0] | a_r[1] | a_r[2];
    mac_op = '0;
    if (state_r == S_SQ) begin
      mac_op.a = asel[MAG_W-1:0];
      mac_op.b = asel[MAG_W-1:0];
    end else begin
      case (pass_r)
        3'd0: begin
          mac_op = '{a: tm_r[0], b: tm_r[3], neg_ab: tn_r[0] ^ tn_r[3],
                     c: tm_r[1], e: tm_r[2], neg_ce: ~(tn_r[1] ^ tn_r[2])};
        end
        3'd1: begin
          mac_op = '{a: dm_r[0], b: tm_r[3], neg_ab: dn_r[0] ^ tn_r[3],
                     c: dm_r[3], e: tm_r[1], neg_ce: ~(dn_r[3] ^ tn_r[1])};
        end
        3'd2: begin
          mac_op = '{a: dm_r[1], b: tm_r[3], neg_ab: dn_r[1] ^ tn_r[3],
                     c: dm_r[4], e: tm_r[1], neg_ce: ~(dn_r[4] ^ tn_r[1])};
        end
        3'd3: begin
          mac_op = '{a: dm_r[2], b: tm_r[3], neg_ab: dn_r[2] ^ tn_r[3],
                     c: dm_r[5], e: tm_r[1], neg_ce: ~(dn_r[5] ^ tn_r[1])};
        end
        3'd4: begin
          mac_op = '{a: dm_r[3], b: tm_r[0], neg_ab: dn_r[3] ^ tn_r[0],
                     c: dm_r[0], e: tm_r[2], neg_ce: ~(dn_r[0] ^ tn_r[2])};
        end
        3'd5: begin
          mac_op = '{a: dm_r[4], b: tm_r[0], neg_ab: dn_r[4] ^ tn_r[0],
                     c: dm_r[1], e: tm_r[2], neg_ce: ~(dn_r[1] ^ tn_r[2])};
        end
        3'd6: begin
          mac_op = '{a: dm_r[5], b: tm_r[0], neg_ab: dn_r[5] ^ tn_r[0],
                     c: dm_r[2], e: tm_r[2], neg_ce: ~(dn_r[2] ^ tn_r[2])};
        end
        default: mac_op = '0;
      endcase
    end
  end

  assign mac_start = (state_r == S_MAC) || (state_r == S_SQ);
  assign dv_num    = NUM_W'({asel[MAG_W-1:0], OUT_FRAC_BITS'(0)}) + NUM_W'(len_r >> 1);
  assign qs        = (dv_quo > ONE_OUT) ? ONE_OUT : dv_quo;
  assign vo_idx    = vec_r ? 3'd3 + {1'b0, comp_r} : {1'b0, comp_r};

  ttf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .op     (mac_op),
    .done   (mac_done),
    .result (mac_res)
  );

  ttf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SQRT),
    .x     (sum_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  ttf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV),
    .num   (dv_num),
    .den   (len_r),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hp_nxt    = hp_r;
    ht_nxt    = ht_r;
    tri_nxt   = tri_r;
    dr_nxt    = dr_r;
    tr_nxt    = tr_r;
    dm_nxt    = dm_r;
    tm_nxt    = tm_r;
    dn_nxt    = dn_r;
    tn_nxt    = tn_r;
    pass_nxt  = pass_r;
    w_nxt     = w_r;
    vec_nxt   = vec_r;
    a_nxt     = a_r;
    an_nxt    = an_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    comp_nxt  = comp_r;
    vo_nxt    = vo_r;
    degen_nxt = degen_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    wsel      = vec_r ? w_r[4] : w_r[1];
    wabs      = '0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_r == 2'd2) begin
            cnt_nxt   = 2'd0;
            dr_nxt    = dsub;
            tr_nxt    = tsub;
            tri_nxt   = in_tdata[5*POS_W +: TRI_W];
            degen_nxt = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (cnt_r[0]) hp_nxt[3+i] = in_tdata[i*POS_W +: POS_W];
              else          hp_nxt[i]   = in_tdata[i*POS_W +: POS_W];
            end
            if (cnt_r[0]) begin
              ht_nxt[2] = in_tdata[3*POS_W +: POS_W];
              ht_nxt[3] = in_tdata[4*POS_W +: POS_W];
            end else begin
              ht_nxt[0] = in_tdata[3*POS_W +: POS_W];
              ht_nxt[1] = in_tdata[4*POS_W +: POS_W];
            end
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_SHIFT: begin
        for (int i = 0; i < 6; i++) begin
          dm_nxt[i] = MAG_W'(dmag[i] >> dsh);
          dn_nxt[i] = dr_r[i][DELTA_W-1];
        end
        for (int i = 0; i < 4; i++) begin
          tm_nxt[i] = MAG_W'(tmag[i] >> tsh);
          tn_nxt[i] = tr_r[i][DELTA_W-1];
        end
        pass_nxt  = 3'd0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        state_nxt = S_MACW;
      end
      S_MACW: begin
        if (mac_done) begin
          w_nxt[pass_r] = mac_res;
          if (pass_r == 3'd0 && mac_res == '0) begin
            degen_nxt = 1'b1;
            for (int i = 0; i < 6; i++) vo_nxt[i] = '0;
            state_nxt = S_OUT;
          end else if (pass_r == 3'(N_PASS - 1)) begin
            vec_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            pass_nxt  = pass_r + 3'd1;
            state_nxt = S_MAC;
          end
        end
      end
      S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          wsel       = vec_r ? w_r[4+i] : w_r[1+i];
          wabs       = wsel[ACC_W-1] ? -wsel : wsel;
          a_nxt[i]   = wabs[VMAG_W-1:0];
          an_nxt[i]  = wsel[ACC_W-1] ^ w_r[0][ACC_W-1];
        end
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (aor == '0) begin
          degen_nxt = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (vec_r) vo_nxt[3+i] = '0;
            else       vo_nxt[i]   = '0;
          end
          if (vec_r) begin
            state_nxt = S_OUT;
          end else begin
            vec_nxt   = 1'b1;
            state_nxt = S_LOAD;
          end
        end else if (|aor[VMAG_W-1:MAG_W]) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] >> 1;
        end else if (!aor[MAG_W-1]) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] << 1;
        end else begin
          comp_nxt  = 2'd0;
          sum_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (mac_done) begin
          sum_nxt = sum_r + mac_res[SUM_W-1:0];
          if (comp_r == 2'd2) begin
            state_nxt = S_SQRT;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQRT: begin
        state_nxt = S_SQRTW;
      end
      S_SQRTW: begin
        if (sq_done) begin
          len_nxt   = sq_root;
          comp_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (dv_done) begin
          vo_nxt[vo_idx] = an_r[comp_r] ? OUT_W'(-qs) : OUT_W'(qs);
          if (comp_r != 2'd2) begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_DIV;
          end else if (vec_r) begin
            state_nxt = S_OUT;
          end else begin
            vec_nxt   = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = OUT_TDATA_W'({tri_r, vo_r[5], vo_r[4], vo_r[3],
                                    vo_r[2], vo_r[1], vo_r[0]});
          ou_nxt    = degen_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
      uv_r    <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        uv_r <= cfg_data;
      end
    end
    hp_r    <= hp_nxt;
    ht_r    <= ht_nxt;
    tri_r   <= tri_nxt;
    dr_r    <= dr_nxt;
    tr_r    <= tr_nxt;
    dm_r    <= dm_nxt;
    tm_r    <= tm_nxt;
    dn_r    <= dn_nxt;
    tn_r    <= tn_nxt;
    pass_r  <= pass_nxt;
    w_r     <= w_nxt;
    vec_r   <= vec_nxt;
    a_r     <= a_nxt;
    an_r    <= an_nxt;
    sum_r   <= sum_nxt;
    len_r   <= len_nxt;
    comp_r  <= comp_nxt;
    vo_r    <= vo_nxt;
    degen_r <= degen_nxt;
    od_r    <= od_nxt;
    ou_r    <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  a_word_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_OUT))
    else $error("result word appeared without passing the output state");

  a_third_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cnt_r == 2'd2) |=> (state_r == S_SHIFT && cnt_r == 2'd0))
    else $error("third corner did not start the frame computation");

  a_mac_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == S_MACW || state_r == S_SQW))
    else $error("multiply unit finished outside a waiting state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("corner count out of range");

endmodule
